FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge, quiet while rst is high.
`define FDMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clk edge, including during reset.
`define FDMD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fdmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fdmd_pkg;

  localparam int PIX_W           = 8;
  localparam int MAX_PIXELS_LOG2 = 22;
  localparam int SUM_W           = MAX_PIXELS_LOG2 + 8;
  localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
  // threshold times pixel count
  localparam int BOUND_W         = CNT_W + PIX_W;

  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd5;

  // floor(s / 3) for s <= 765 as (s * 683) >> 11
  localparam int RGB_SUM_W   = PIX_W + 2;
  localparam int RECIP_SHIFT = 11;
  localparam int RECIP_W     = 10;
  localparam logic [RECIP_W-1:0] RECIP3 = 10'd683;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } accum_snap_t;

  function automatic logic [PIX_W-1:0] grey_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [RGB_SUM_W-1:0]         s;
    logic [RGB_SUM_W+RECIP_W-1:0] p;
    s = {2'b00, r} + {2'b00, g} + {2'b00, b};
    p = {{RECIP_W{1'b0}}, s} * {{RGB_SUM_W{1'b0}}, RECIP3};
    return p[RECIP_SHIFT +: PIX_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fdmd_accum.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fdmd_accum (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire logic                           last,
  input  wire logic [fdmd_pkg::PIX_W-1:0]     grey_a,
  input  wire logic [fdmd_pkg::PIX_W-1:0]     grey_b,
  output logic      [fdmd_pkg::PIX_W-1:0]     diff,
  output fdmd_pkg::accum_snap_t               snap
);

  logic [fdmd_pkg::SUM_W-1:0]   difference_sum;
  logic [fdmd_pkg::CNT_W-1:0]   pixel_count;

  logic [fdmd_pkg::SUM_W:0]     sum_wide;
  logic [fdmd_pkg::SUM_W-1:0]   difference_sum_next;
  logic [fdmd_pkg::CNT_W-1:0]   pixel_count_next;
  logic                         count_full;

  always_comb begin
    diff = (grey_a > grey_b) ? (grey_a - grey_b) : (grey_b - grey_a);
    sum_wide = {1'b0, difference_sum}
             + {{(fdmd_pkg::SUM_W + 1 - fdmd_pkg::PIX_W){1'b0}}, diff};
    // saturate at all ones
    difference_sum_next = sum_wide[fdmd_pkg::SUM_W] ? {fdmd_pkg::SUM_W{1'b1}}
                                                    : sum_wide[fdmd_pkg::SUM_W-1:0];
    count_full = &pixel_count;
    if (count_full) begin
      pixel_count_next = pixel_count;
    end else begin
      pixel_count_next = pixel_count + 1'b1;
    end
    snap.sum   = difference_sum_next;
    snap.count = pixel_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      difference_sum <= '0;
      pixel_count    <= '0;
    end else if (step) begin
      if (last) begin
        difference_sum <= '0;
        pixel_count    <= '0;
      end else begin
        difference_sum <= difference_sum_next;
        pixel_count    <= pixel_count_next;
      end
    end
  end

  `FDMD_ASSERT(a_clear_on_last, step && last |=> difference_sum == '0 && pixel_count == '0, "accumulators not cleared after frame end")
  `FDMD_ASSERT(a_sum_monotonic, step && !last |=> difference_sum >= $past(difference_sum), "difference sum decreased inside a frame")
  `FDMD_ASSERT(a_hold_idle, !step |=> $stable(pixel_count) && $stable(difference_sum), "accumulators moved without a beat")

endmodule

`default_nettype wire

FILE: rtl/frame_difference_motion_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame-difference motion detector. Takes one co-located RGBA pixel pair per
// beat in raster order and returns one result per pixel: both grey levels
// (floor of the RGB mean), their absolute difference and both alphas. On the
// beat flagged frame_end the result carries frame_done and motion_found, set
// when the frame's summed difference is at least motion_threshold times its
// pixel count; the sums then restart. One pixel per clock is sustained while
// out_stall is low; a pixel passes through the input register, grey
// conversion, accumulate, and compare and output register in turn, and the
// pipeline keeps taking pixels while a result waits until all four stages
// are full. Write the threshold only with the pipeline empty.

`include "assert_macros.svh"

module frame_difference_motion_detector (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [fdmd_pkg::PIX_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [fdmd_pkg::PIX_W-1:0] red_first,
  input  wire logic [fdmd_pkg::PIX_W-1:0] green_first,
  input  wire logic [fdmd_pkg::PIX_W-1:0] blue_first,
  input  wire logic [fdmd_pkg::PIX_W-1:0] alpha_first,
  input  wire logic [fdmd_pkg::PIX_W-1:0] red_second,
  input  wire logic [fdmd_pkg::PIX_W-1:0] green_second,
  input  wire logic [fdmd_pkg::PIX_W-1:0] blue_second,
  input  wire logic [fdmd_pkg::PIX_W-1:0] alpha_second,
  input  wire logic                       frame_end,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [fdmd_pkg::PIX_W-1:0] grey_first,
  output logic      [fdmd_pkg::PIX_W-1:0] grey_second,
  output logic      [fdmd_pkg::PIX_W-1:0] grey_difference,
  output logic      [fdmd_pkg::PIX_W-1:0] alpha_out_first,
  output logic      [fdmd_pkg::PIX_W-1:0] alpha_out_second,
  output logic                            frame_done,
  output logic                            motion_found
);

  logic [fdmd_pkg::PIX_W-1:0] motion_threshold;

  // stage 0: input register
  logic                       v0;
  logic [fdmd_pkg::PIX_W-1:0] r1_s0, g1_s0, b1_s0, a1_s0;
  logic [fdmd_pkg::PIX_W-1:0] r2_s0, g2_s0, b2_s0, a2_s0;
  logic                       last_s0;

  // stage 1: grey levels
  logic                       v1;
  logic [fdmd_pkg::PIX_W-1:0] grey1_s1, grey2_s1, a1_s1, a2_s1;
  logic                       last_s1;

  // stage 2: difference and accumulator snapshot
  logic                       v2;
  logic [fdmd_pkg::PIX_W-1:0] grey1_s2, grey2_s2, diff_s2, a1_s2, a2_s2;
  logic                       last_s2;
  fdmd_pkg::accum_snap_t      snap_s2;

  logic                         in_take, go1, go2, go3, out_take;
  logic [fdmd_pkg::PIX_W-1:0]   diff;
  fdmd_pkg::accum_snap_t        snap;
  logic [fdmd_pkg::BOUND_W-1:0] bound;

  // each stage moves when the next one is empty or moving
  always_comb begin
    out_take = out_valid && !out_stall;
    go3      = v2 && (!out_valid || !out_stall);
    go2      = v1 && (!v2 || go3);
    go1      = v0 && (!v1 || go2);
    in_stall = v0 && !go1;
    in_take  = in_valid && !in_stall;
    // 8 x 23 bit product; the user must move the threshold only with the pipeline empty, the block does not enforce it
    bound    = {{fdmd_pkg::PIX_W{1'b0}}, snap_s2.count}
             * {{fdmd_pkg::CNT_W{1'b0}}, motion_threshold};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_threshold <= fdmd_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      motion_threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        v0 <= 1'b1;
      end else if (go1) begin
        v0 <= 1'b0;
      end
      if (go1) begin
        v1 <= 1'b1;
      end else if (go2) begin
        v1 <= 1'b0;
      end
      if (go2) begin
        v2 <= 1'b1;
      end else if (go3) begin
        v2 <= 1'b0;
      end
      if (go3) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      r1_s0   <= red_first;
      g1_s0   <= green_first;
      b1_s0   <= blue_first;
      a1_s0   <= alpha_first;
      r2_s0   <= red_second;
      g2_s0   <= green_second;
      b2_s0   <= blue_second;
      a2_s0   <= alpha_second;
      last_s0 <= frame_end;
    end
    if (go1) begin
      grey1_s1 <= fdmd_pkg::grey_of(r1_s0, g1_s0, b1_s0);
      grey2_s1 <= fdmd_pkg::grey_of(r2_s0, g2_s0, b2_s0);
      a1_s1    <= a1_s0;
      a2_s1    <= a2_s0;
      last_s1  <= last_s0;
    end
    if (go2) begin
      grey1_s2 <= grey1_s1;
      grey2_s2 <= grey2_s1;
      diff_s2  <= diff;
      a1_s2    <= a1_s1;
      a2_s2    <= a2_s1;
      last_s2  <= last_s1;
      snap_s2  <= snap;
    end
    if (go3) begin
      grey_first       <= grey1_s2;
      grey_second      <= grey2_s2;
      grey_difference  <= diff_s2;
      alpha_out_first  <= a1_s2;
      alpha_out_second <= a2_s2;
      frame_done       <= last_s2;
      motion_found     <= last_s2 && ({1'b0, snap_s2.sum} >= bound);
    end
  end

  fdmd_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .step      (go2),
    .last      (last_s1),
    .grey_a    (grey1_s1),
    .grey_b    (grey2_s1),
    .diff      (diff),
    .snap      (snap)
  );

  `FDMD_ASSERT(a_motion_only_at_end, out_valid && !frame_done |-> !motion_found, "motion flagged on a pixel that does not end a frame")
  `FDMD_ASSERT(a_stall_means_full, in_stall |-> v0 && v1 && v2 && out_valid && out_stall, "input stalled with room in the pipeline")
  `FDMD_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

`default_nettype wire
